// File: hdl/mlse_pkg.sv
// ----------------------------------------------------------------------------
// Morse LED symbol encoder package
// Symbol kinds, the character descriptor, the Morse table and LED masks.
// ----------------------------------------------------------------------------
package mlse_pkg;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		KIND_PREAMBLE = 3'd0,
		KIND_START    = 3'd1,
		KIND_SHORT    = 3'd2,
		KIND_LONG     = 3'd3,
		KIND_STOP     = 3'd4
	} symbol_kind_t;

	typedef struct packed {
		logic       first;
		logic       last;
		logic [2:0] len;
		logic [3:0] pat;
	} desc_t;

	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_Z = 8'h7A;

	// {count, pattern}; first symbol in pattern bit 0, set bit means long
	function automatic logic [6:0] morse_code(input logic [4:0] letter);
		logic [6:0] code;
		case (letter)
			5'd0:    code = 7'h22;
			5'd1:    code = 7'h41;
			5'd2:    code = 7'h45;
			5'd3:    code = 7'h31;
			5'd4:    code = 7'h10;
			5'd5:    code = 7'h44;
			5'd6:    code = 7'h33;
			5'd7:    code = 7'h40;
			5'd8:    code = 7'h20;
			5'd9:    code = 7'h4E;
			5'd10:   code = 7'h35;
			5'd11:   code = 7'h42;
			5'd12:   code = 7'h23;
			5'd13:   code = 7'h21;
			5'd14:   code = 7'h37;
			5'd15:   code = 7'h46;
			5'd16:   code = 7'h4B;
			5'd17:   code = 7'h32;
			5'd18:   code = 7'h30;
			5'd19:   code = 7'h11;
			5'd20:   code = 7'h34;
			5'd21:   code = 7'h48;
			5'd22:   code = 7'h36;
			5'd23:   code = 7'h49;
			5'd24:   code = 7'h4D;
			5'd25:   code = 7'h43;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

	function automatic logic [2:0] kind_mask(input symbol_kind_t kind);
		logic [2:0] mask;
		case (kind)
			KIND_PREAMBLE: mask = 3'd7;
			KIND_START:    mask = 3'd1;
			KIND_SHORT:    mask = 3'd2;
			KIND_LONG:     mask = 3'd4;
			KIND_STOP:     mask = 3'd6;
			default:       mask = 3'd0;
		endcase
		return mask;
	endfunction

endpackage

// File: hdl/mlse_front.sv
// ----------------------------------------------------------------------------
// Morse LED symbol encoder front end
// Accepts characters and registers a descriptor of the run they cause.
// ----------------------------------------------------------------------------
module mlse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_code,
	input  logic                first_in_message,
	input  logic                last_in_message,
	output logic                push,
	input  logic                push_ready,
	output mlse_pkg::desc_t     desc
);
	import mlse_pkg::*;

	logic       v_s1;
	desc_t      d_s1;
	desc_t      d_new;
	logic       is_letter;
	logic [7:0] offset;
	logic [6:0] code;

	assign is_letter = (char_code >= CHAR_A) && (char_code <= CHAR_Z);
	assign offset    = char_code - CHAR_A;
	assign code      = morse_code(offset[4:0]);

	always_comb begin
		d_new.first = first_in_message;
		d_new.last  = last_in_message;
		d_new.len   = is_letter ? code[6:4] : 3'd0;
		d_new.pat   = code[3:0];
	end

	assign in_ready = !v_s1 || push_ready;
	assign push     = v_s1;
	assign desc     = d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_s1 <= d_new;
		end
	end

endmodule

// File: hdl/mlse_queue.sv
// ----------------------------------------------------------------------------
// Morse LED symbol encoder descriptor queue
// Short first-in first-out queue between front end and sequencer.
// ----------------------------------------------------------------------------
module mlse_queue #(
	parameter int DEPTH = mlse_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  mlse_pkg::desc_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output mlse_pkg::desc_t rd_data
);
	import mlse_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = count_q != CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hdl/mlse_back.sv
// ----------------------------------------------------------------------------
// Morse LED symbol encoder sequencer
// Walks one descriptor into its symbols, one per cycle unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
module mlse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  mlse_pkg::desc_t q_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      symbol_kind,
	output logic [2:0]      led_mask,
	output logic            last_of_run
);
	import mlse_pkg::*;

	logic         busy_q;
	desc_t        cur_q;
	logic [2:0]   idx_q;
	logic         m_valid_q;
	symbol_kind_t kind_q;
	logic [2:0]   mask_q;
	logic         last_q;

	logic         slot_free;
	logic         adv;
	logic         last_sym;
	logic [2:0]   pos;
	logic [2:0]   pos_m1;
	logic [3:0]   total;
	symbol_kind_t kind_c;

	assign slot_free = !m_valid_q || out_ready;
	assign adv       = busy_q && slot_free;
	assign pos       = idx_q - {2'b00, cur_q.first};
	assign pos_m1    = pos - 3'd1;
	assign total     = {3'b000, cur_q.first} + {1'b0, cur_q.len} + 4'd2
		+ {3'b000, cur_q.last};
	assign last_sym  = ({1'b0, idx_q} + 4'd1) == total;
	assign q_ready   = !busy_q || (adv && last_sym);

	always_comb begin
		if (cur_q.first && idx_q == 3'd0) begin
			kind_c = KIND_PREAMBLE;
		end else if (pos == 3'd0) begin
			kind_c = KIND_START;
		end else if (pos <= cur_q.len) begin
			kind_c = cur_q.pat[pos_m1[1:0]] ? KIND_LONG : KIND_SHORT;
		end else if (pos == cur_q.len + 3'd1) begin
			kind_c = KIND_STOP;
		end else begin
			kind_c = KIND_PREAMBLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (q_valid && q_ready) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv) begin
				if (last_sym) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			if (adv) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			cur_q <= q_data;
		end
		if (adv) begin
			kind_q <= kind_c;
			mask_q <= kind_mask(kind_c);
			last_q <= last_sym;
		end
	end

	assign out_valid   = m_valid_q;
	assign symbol_kind = kind_q;
	assign led_mask    = mask_q;
	assign last_of_run = last_q;

endmodule

// File: hdl/morse_led_symbol_encoder.sv
// Path: front-end register, descriptor queue, then the sequencer's output register.
// Throughput: one symbol per cycle unless m_axis_tready stalls; a character gives
// two to eight symbols (preamble, start, up to four Morse symbols, stop, preamble).
// The front end keeps accepting into a two-entry descriptor queue while symbols drain.
// Reset: arst_n clears all valid flags and pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
// Morse LED symbol encoder
// Turns each character into a framed run of three-LED link symbols.
// ----------------------------------------------------------------------------
module morse_led_symbol_encoder #(
	parameter int QUEUE_DEPTH = mlse_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  logic       s_axis_tuser,   // [0] first_in_message
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [2:0] symbol_kind, [5:3] led_mask, [7:6] zero
	output logic       m_axis_tlast
);
	import mlse_pkg::*;

	logic       push;
	logic       push_ready;
	desc_t      f_desc;
	logic       q_valid;
	logic       q_ready;
	desc_t      q_data;
	logic [2:0] kind;
	logic [2:0] mask;

	mlse_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.char_code        (s_axis_tdata),
		.first_in_message (s_axis_tuser),
		.last_in_message  (s_axis_tlast),
		.push             (push),
		.push_ready       (push_ready),
		.desc             (f_desc)
	);

	mlse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push),
		.wr_ready (push_ready),
		.wr_data  (f_desc),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	mlse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_data      (q_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.symbol_kind (kind),
		.led_mask    (mask),
		.last_of_run (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, mask, kind};

`ifndef SYNTHESIS
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			(kind == KIND_STOP || kind == KIND_PREAMBLE))
		else $error("run ends on a symbol other than stop or preamble");

	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind == KIND_START |-> !m_axis_tlast)
		else $error("start symbol marked as end of run");

	a_mask_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> mask == kind_mask(symbol_kind_t'(kind)))
		else $error("LED mask does not match symbol kind");
`endif

endmodule

// File: dv/tb_morse_led_symbol_encoder.sv
// ----------------------------------------------------------------------------
// Morse LED symbol encoder testbench
// Streams characters into the encoder and checks each symbol beat
// (kind, LED mask, run end) against a predicted run built from a Morse table.
// Directed edge cases come first. Random messages and noise follow under
// three idling profiles.
// ----------------------------------------------------------------------------
module tb_morse_led_symbol_encoder;

	import mlse_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [7:0] char_code;
		logic       first;
		logic       last;
	} char_beat_t;

	typedef struct {
		symbol_kind_t kind;
		logic [2:0]   mask;
		logic         last;
	} symbol_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;   // [7:0] char_code
	logic       s_axis_tuser = 1'b0;   // [0] first_in_message
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [2:0] symbol_kind, [5:3] led_mask, [7:6] zero
	logic       m_axis_tlast;

	char_beat_t   pending_chars[$];
	symbol_beat_t expected_symbols[$];
	char_beat_t   send_beat;
	int           send_idle_pct = 34;
	int           recv_idle_pct = 72;
	int           error_count = 0;
	int           quiet_cycles = 0;

	string morse_of[26] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--.."
	};

	morse_led_symbol_encoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	function automatic logic [2:0] led_mask_for(input symbol_kind_t kind);
		case (kind)
			KIND_PREAMBLE: return 3'd7;
			KIND_START:    return 3'd1;
			KIND_SHORT:    return 3'd2;
			KIND_LONG:     return 3'd4;
			KIND_STOP:     return 3'd6;
			default:       return 3'd0;
		endcase
	endfunction

	function automatic void predict_symbols(input logic [7:0] char_code, input logic first,
			input logic last);
		symbol_kind_t kinds[$];
		symbol_beat_t sym;
		string        code;
		if (first)
			kinds.push_back(KIND_PREAMBLE);
		kinds.push_back(KIND_START);
		if (char_code >= CHAR_A && char_code <= CHAR_Z) begin
			code = morse_of[5'(char_code - CHAR_A)];
			for (int i = 0; i < code.len(); i++)
				kinds.push_back(code[i] == "-" ? KIND_LONG : KIND_SHORT);
		end
		kinds.push_back(KIND_STOP);
		if (last)
			kinds.push_back(KIND_PREAMBLE);
		foreach (kinds[i]) begin
			sym.kind = kinds[i];
			sym.mask = led_mask_for(kinds[i]);
			sym.last = (i == kinds.size() - 1);
			expected_symbols.push_back(sym);
		end
	endfunction

	task automatic queue_char(input logic [7:0] char_code, input logic first, input logic last);
		char_beat_t beat;
		beat.char_code = char_code;
		beat.first = first;
		beat.last = last;
		pending_chars.push_back(beat);
	endtask

	// mostly well-formed messages of lowercase letters; the rest is noise
	task automatic queue_messages(input int n_chars);
		int queued;
		int len;
		queued = 0;
		while (queued < n_chars) begin
			if ($urandom_range(99) < 75) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					queue_char(CHAR_A + 8'($urandom_range(25)), i == 0, i == len - 1);
				queued += len;
			end else begin
				queue_char(8'($urandom_range(255)), 1'($urandom), 1'($urandom));
				queued++;
			end
		end
	endtask

	task automatic wait_link_idle();
		do
			@(negedge clk);
		while (pending_chars.size() != 0 || s_axis_tvalid || expected_symbols.size() != 0);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'd0;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				send_beat = pending_chars.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= send_beat.char_code;
				s_axis_tuser <= send_beat.first;
				s_axis_tlast <= send_beat.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		symbol_beat_t want;
		symbol_kind_t got_kind;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (s_axis_tvalid && s_axis_tready)
				predict_symbols(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got_kind = symbol_kind_t'(m_axis_tdata[2:0]);
				if (expected_symbols.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected symbol beat: tdata=%h tlast=%b",
							m_axis_tdata, m_axis_tlast);
				end else begin
					want = expected_symbols.pop_front();
					if (got_kind !== want.kind || m_axis_tdata[5:3] !== want.mask ||
							m_axis_tdata[7:6] !== 2'b00 || m_axis_tlast !== want.last) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display({"symbol mismatch: expected kind=%0d mask=%0d pad=0 ",
								"last=%b, got kind=%0d mask=%0d pad=%0d last=%b"},
								want.kind, want.mask, want.last, m_axis_tdata[2:0],
								m_axis_tdata[5:3], m_axis_tdata[7:6], m_axis_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 34;
		recv_idle_pct = 72;
		queue_char("a", 1'b1, 1'b1);
		queue_char("z", 1'b0, 1'b0);
		queue_char("t", 1'b1, 1'b0);
		queue_char("e", 1'b0, 1'b1);
		queue_char("j", 1'b1, 1'b1);
		queue_char("q", 1'b0, 1'b0);
		queue_char("b", 1'b0, 1'b0);
		queue_char("y", 1'b0, 1'b1);
		queue_char(8'h60, 1'b1, 1'b0);
		queue_char(8'h7B, 1'b0, 1'b1);
		queue_char(8'h00, 1'b0, 1'b0);
		queue_char(8'hFF, 1'b1, 1'b1);
		queue_char(8'h80, 1'b0, 1'b0);
		queue_char("A", 1'b1, 1'b0);
		queue_char("Z", 1'b0, 1'b1);
		queue_char("0", 1'b0, 1'b0);
		queue_char(8'h7F, 1'b1, 1'b1);
		queue_char("h", 1'b0, 1'b0);
		queue_char("o", 1'b1, 1'b1);
		queue_messages(125);
		wait_link_idle();

		send_idle_pct = 72;
		recv_idle_pct = 34;
		queue_messages(145);
		wait_link_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_messages(145);
		wait_link_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		error_count += expected_symbols.size();
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
hdl/mlse_pkg.sv
hdl/mlse_front.sv
hdl/mlse_queue.sv
hdl/mlse_back.sv
hdl/morse_led_symbol_encoder.sv
dv/tb_morse_led_symbol_encoder.sv
